// ----- src/synth_voice_allocator_macros.svh -----
// Assertion macros shared by the voice allocator modules.
`ifndef SYNTH_VOICE_ALLOCATOR_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_MACROS_SVH

// General form with an explicit clock and active-low reset.
`define SVA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Short form for modules that use clk_i and rst_ni.
`define SVA_CHECK(lbl, prop, msg) `SVA_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- src/sva_pkg.sv -----
// Types and constants of the voice allocator.
package sva_pkg;

  localparam int NUM_VOICES_DEF = 8;
  localparam int KIND_W = 2;
  localparam int VOICE_FIELD_W = 3;
  localparam int OUTCOME_W = 2;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_PLAY    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_RETRIG  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OC_DONE    = 2'd0,
    OC_NONE    = 2'd1,
    OC_IGNORED = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    VS_FREE     = 2'd0,
    VS_PLAYING  = 2'd1,
    VS_RELEASED = 2'd2,
    VS_ALLOC    = 2'd3
  } vstat_e;

  typedef enum logic {
    LIST_PLAY = 1'b0,
    LIST_REL  = 1'b1
  } list_sel_e;

  typedef enum logic [1:0] {
    LOP_NONE   = 2'd0,
    LOP_REMOVE = 2'd1,
    LOP_APPEND = 2'd2
  } list_op_e;

  typedef struct packed {
    list_op_e  op;
    list_sel_e sel;
    logic      take_first;
  } list_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH,
    S_RESP
  } state_e;

endpackage

// ----- src/sva_intf.sv -----
// Handshake interfaces for the command and result channels.
interface sva_in_if;
  logic                               valid;
  logic                               ready;
  logic [sva_pkg::KIND_W-1:0]         kind;
  logic [sva_pkg::VOICE_FIELD_W-1:0]  voice_in;

  modport source (output valid, output kind, output voice_in, input ready);
  modport sink (input valid, input kind, input voice_in, output ready);
endinterface

interface sva_out_if;
  logic                               valid;
  logic                               ready;
  logic [sva_pkg::VOICE_FIELD_W-1:0]  voice_out;
  logic                               stolen;
  logic                               stolen_from_playing;
  logic [sva_pkg::OUTCOME_W-1:0]      outcome;

  modport source (output valid, output voice_out, output stolen,
                  output stolen_from_playing, output outcome, input ready);
  modport sink (input valid, input voice_out, input stolen,
                input stolen_from_playing, input outcome, output ready);
endinterface

// ----- src/synth_voice_allocator.sv -----
// Top level of the voice allocator: command decode, free pool and voice status.
//
//  Channel  Direction  Payload                                            Handshake
//  in_i     sink       kind, voice_in                                     valid/ready
//  out_o    source     voice_out, stolen, stolen_from_playing, outcome    valid/ready
//
// An allocate from the free pool or a play passes from S_CHECK through S_FINISH to S_RESP.
// An ignored word or an allocate that finds nothing at all goes from S_CHECK straight to S_RESP.
// A steal, release or retrigger passes through S_SCAN, where the list scan unit scans one
// list entry a cycle, and then through S_FINISH to S_RESP.
// The block takes one word at a time; in_i is ready only while idle.
// A stalled result holds in out_o until taken. Reset needs no clearing pass.
`include "synth_voice_allocator_macros.svh"

module synth_voice_allocator #(
  parameter int NumVoices = sva_pkg::NUM_VOICES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sva_in_if.sink     in_i,
  sva_out_if.source  out_o
);

  localparam int VoiceW = $clog2(NumVoices);
  localparam int CntW   = $clog2(NumVoices + 1);
  localparam int StDepth = 2 ** VoiceW;

  sva_pkg::vstat_e status_mem [StDepth];

  sva_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]     free_cnt_q, free_cnt_d;
  sva_pkg::kind_e      kind_q, kind_d;
  logic [sva_pkg::VOICE_FIELD_W-1:0] vin_q, vin_d;
  logic [VoiceW-1:0]   voice_q, voice_d;
  logic                stolen_q, stolen_d;
  logic                from_play_q, from_play_d;
  sva_pkg::outcome_e   outcome_q, outcome_d;
  logic                app_q, app_d;
  sva_pkg::list_sel_e  app_sel_q, app_sel_d;
  sva_pkg::vstat_e     new_st_q, new_st_d;
  sva_pkg::vstat_e     st_rdata_q;

  sva_pkg::vstat_e     st_cur;
  sva_pkg::list_cmd_t  list_cmd;
  logic                list_done;
  logic [VoiceW-1:0]   list_taken;
  logic [CntW-1:0]     play_cnt;
  logic [CntW-1:0]     rel_cnt;
  logic                in_fire;
  logic                st_we;

  assign in_fire = in_i.valid && in_i.ready;

  always_comb begin
    st_cur = (CntW'(voice_q) < free_cnt_q) ? sva_pkg::VS_FREE : st_rdata_q;

    state_d     = state_q;
    free_cnt_d  = free_cnt_q;
    kind_d      = kind_q;
    vin_d       = vin_q;
    voice_d     = voice_q;
    stolen_d    = stolen_q;
    from_play_d = from_play_q;
    outcome_d   = outcome_q;
    app_d       = app_q;
    app_sel_d   = app_sel_q;
    new_st_d    = new_st_q;
    list_cmd    = '{op: sva_pkg::LOP_NONE, sel: sva_pkg::LIST_PLAY, take_first: 1'b0};
    st_we       = 1'b0;
    in_i.ready  = 1'b0;
    out_o.valid = 1'b0;

    case (state_q)
      sva_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          kind_d      = sva_pkg::kind_e'(in_i.kind);
          vin_d       = in_i.voice_in;
          voice_d     = VoiceW'(in_i.voice_in);
          stolen_d    = 1'b0;
          from_play_d = 1'b0;
          outcome_d   = sva_pkg::OC_DONE;
          app_d       = 1'b0;
          state_d     = sva_pkg::S_CHECK;
        end
      end
      sva_pkg::S_CHECK: begin
        if (kind_q == sva_pkg::KIND_ALLOC) begin
          new_st_d = sva_pkg::VS_ALLOC;
          if (free_cnt_q != '0) begin
            free_cnt_d = free_cnt_q - 1'b1;
            voice_d    = VoiceW'(free_cnt_q - 1'b1);
            state_d    = sva_pkg::S_FINISH;
          end else if (rel_cnt != '0) begin
            list_cmd = '{op: sva_pkg::LOP_REMOVE, sel: sva_pkg::LIST_REL, take_first: 1'b1};
            stolen_d = 1'b1;
            state_d  = sva_pkg::S_SCAN;
          end else if (play_cnt != '0) begin
            list_cmd    = '{op: sva_pkg::LOP_REMOVE, sel: sva_pkg::LIST_PLAY,
                            take_first: 1'b1};
            stolen_d    = 1'b1;
            from_play_d = 1'b1;
            state_d     = sva_pkg::S_SCAN;
          end else begin
            outcome_d = sva_pkg::OC_NONE;
            voice_d   = '0;
            state_d   = sva_pkg::S_RESP;
          end
        end else if (32'(vin_q) >= NumVoices) begin
          outcome_d = sva_pkg::OC_IGNORED;
          state_d   = sva_pkg::S_RESP;
        end else if (kind_q == sva_pkg::KIND_PLAY && st_cur == sva_pkg::VS_ALLOC) begin
          app_d     = 1'b1;
          app_sel_d = sva_pkg::LIST_PLAY;
          new_st_d  = sva_pkg::VS_PLAYING;
          state_d   = sva_pkg::S_FINISH;
        end else if (kind_q == sva_pkg::KIND_RELEASE && st_cur == sva_pkg::VS_PLAYING) begin
          list_cmd  = '{op: sva_pkg::LOP_REMOVE, sel: sva_pkg::LIST_PLAY, take_first: 1'b0};
          app_d     = 1'b1;
          app_sel_d = sva_pkg::LIST_REL;
          new_st_d  = sva_pkg::VS_RELEASED;
          state_d   = sva_pkg::S_SCAN;
        end else if (kind_q == sva_pkg::KIND_RETRIG && st_cur == sva_pkg::VS_RELEASED) begin
          list_cmd  = '{op: sva_pkg::LOP_REMOVE, sel: sva_pkg::LIST_REL, take_first: 1'b0};
          app_d     = 1'b1;
          app_sel_d = sva_pkg::LIST_PLAY;
          new_st_d  = sva_pkg::VS_PLAYING;
          state_d   = sva_pkg::S_SCAN;
        end else begin
          outcome_d = sva_pkg::OC_IGNORED;
          state_d   = sva_pkg::S_RESP;
        end
      end
      sva_pkg::S_SCAN: begin
        if (list_done) begin
          if (stolen_q) begin
            voice_d = list_taken;
          end
          state_d = sva_pkg::S_FINISH;
        end
      end
      sva_pkg::S_FINISH: begin
        st_we = 1'b1;
        if (app_q) begin
          list_cmd = '{op: sva_pkg::LOP_APPEND, sel: app_sel_q, take_first: 1'b0};
        end
        state_d = sva_pkg::S_RESP;
      end
      sva_pkg::S_RESP: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          state_d = sva_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sva_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sva_pkg::S_IDLE;
      free_cnt_q <= CntW'(NumVoices);
    end else begin
      state_q    <= state_d;
      free_cnt_q <= free_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q      <= kind_d;
    vin_q       <= vin_d;
    voice_q     <= voice_d;
    stolen_q    <= stolen_d;
    from_play_q <= from_play_d;
    outcome_q   <= outcome_d;
    app_q       <= app_d;
    app_sel_q   <= app_sel_d;
    new_st_q    <= new_st_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      st_rdata_q <= status_mem[VoiceW'(in_i.voice_in)];
    end
    if (st_we) begin
      status_mem[voice_q] <= new_st_q;
    end
  end

  sva_lists #(
    .NumVoices(NumVoices)
  ) u_lists (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (list_cmd),
    .voice_i    (voice_q),
    .done_o     (list_done),
    .taken_o    (list_taken),
    .play_cnt_o (play_cnt),
    .rel_cnt_o  (rel_cnt)
  );

  assign out_o.voice_out           = (kind_q == sva_pkg::KIND_ALLOC) ?
                                     sva_pkg::VOICE_FIELD_W'(voice_q) : vin_q;
  assign out_o.stolen              = stolen_q;
  assign out_o.stolen_from_playing = from_play_q;
  assign out_o.outcome             = outcome_q;

  `SVA_CHECK(a_top_one_word, in_i.ready |-> !out_o.valid, "Input taken while a result is pending.")
  `SVA_CHECK(a_top_free_shrinks, 1'b1 |=> (free_cnt_q <= $past(free_cnt_q)), "Free pool grew.")
  `SVA_CHECK(a_top_steal_empty, (out_o.valid && out_o.stolen) |-> (free_cnt_q == '0), "Steal with voices still free.")
  `SVA_CHECK(a_top_steal_alloc, (out_o.valid && out_o.stolen) |-> (kind_q == sva_pkg::KIND_ALLOC && out_o.outcome == sva_pkg::OC_DONE), "Steal flagged on a word that is not a granted allocate.")

endmodule

// ----- src/sva_lists.sv -----
// Playing and released age lists with an entry-per-cycle removal scan.
`include "synth_voice_allocator_macros.svh"

module sva_lists #(
  parameter int NumVoices = sva_pkg::NUM_VOICES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sva_pkg::list_cmd_t                  cmd_i,
  input  logic [$clog2(NumVoices)-1:0]        voice_i,
  output logic                                done_o,
  output logic [$clog2(NumVoices)-1:0]        taken_o,
  output logic [$clog2(NumVoices+1)-1:0]      play_cnt_o,
  output logic [$clog2(NumVoices+1)-1:0]      rel_cnt_o
);

  localparam int VoiceW = $clog2(NumVoices);
  localparam int CntW   = $clog2(NumVoices + 1);
  localparam int AddrW  = VoiceW + 1;
  localparam int Depth  = 2 ** AddrW;
  localparam logic [CntW-1:0] Full = CntW'(NumVoices);

  logic [VoiceW-1:0] mem [Depth];

  logic                busy_q, busy_d;
  logic                pend_q, pend_d;
  logic                found_q, found_d;
  logic [CntW-1:0]     rd_idx_q, rd_idx_d;
  logic [CntW-1:0]     wr_idx_q, wr_idx_d;
  logic [CntW-1:0]     play_cnt_q, play_cnt_d;
  logic [CntW-1:0]     rel_cnt_q, rel_cnt_d;
  sva_pkg::list_sel_e  sel_q;
  logic                first_q;
  logic [VoiceW-1:0]   target_q;
  logic [VoiceW-1:0]   taken_q;
  logic [VoiceW-1:0]   rdata_q;

  logic [CntW-1:0]     cur_cnt;
  logic [CntW-1:0]     app_cnt;
  logic                rd_en;
  logic                match;
  logic                copy;
  logic                finish;
  logic                app_en;
  logic                we;
  logic [AddrW-1:0]    waddr;
  logic [VoiceW-1:0]   wdata;
  logic [AddrW-1:0]    raddr;

  always_comb begin
    cur_cnt = (sel_q == sva_pkg::LIST_REL) ? rel_cnt_q : play_cnt_q;
    app_cnt = (cmd_i.sel == sva_pkg::LIST_REL) ? rel_cnt_q : play_cnt_q;
    rd_en   = busy_q && (rd_idx_q < cur_cnt);
    match   = pend_q && !found_q && (first_q || (rdata_q == target_q));
    copy    = pend_q && !match;
    finish  = busy_q && !rd_en && !pend_q;
    app_en  = (cmd_i.op == sva_pkg::LOP_APPEND) && (app_cnt != Full);
    raddr   = {sel_q, rd_idx_q[VoiceW-1:0]};

    we    = 1'b0;
    waddr = {cmd_i.sel, app_cnt[VoiceW-1:0]};
    wdata = voice_i;
    if (app_en) begin
      we = 1'b1;
    end else if (copy) begin
      we    = 1'b1;
      waddr = {sel_q, wr_idx_q[VoiceW-1:0]};
      wdata = rdata_q;
    end

    busy_d     = busy_q;
    pend_d     = rd_en;
    found_d    = found_q || match;
    rd_idx_d   = rd_en ? rd_idx_q + 1'b1 : rd_idx_q;
    wr_idx_d   = copy ? wr_idx_q + 1'b1 : wr_idx_q;
    play_cnt_d = play_cnt_q;
    rel_cnt_d  = rel_cnt_q;

    if (cmd_i.op == sva_pkg::LOP_REMOVE) begin
      busy_d   = 1'b1;
      pend_d   = 1'b0;
      found_d  = 1'b0;
      rd_idx_d = '0;
      wr_idx_d = '0;
    end
    if (app_en) begin
      if (cmd_i.sel == sva_pkg::LIST_REL) begin
        rel_cnt_d = rel_cnt_q + 1'b1;
      end else begin
        play_cnt_d = play_cnt_q + 1'b1;
      end
    end
    if (finish) begin
      busy_d = 1'b0;
      if (found_q) begin
        if (sel_q == sva_pkg::LIST_REL) begin
          rel_cnt_d = rel_cnt_q - 1'b1;
        end else begin
          play_cnt_d = play_cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      play_cnt_q <= '0;
      rel_cnt_q  <= '0;
    end else begin
      busy_q     <= busy_d;
      pend_q     <= pend_d;
      found_q    <= found_d;
      rd_idx_q   <= rd_idx_d;
      wr_idx_q   <= wr_idx_d;
      play_cnt_q <= play_cnt_d;
      rel_cnt_q  <= rel_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == sva_pkg::LOP_REMOVE) begin
      sel_q    <= cmd_i.sel;
      first_q  <= cmd_i.take_first;
      target_q <= voice_i;
    end
    if (match) begin
      taken_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  assign done_o     = finish;
  assign taken_o    = taken_q;
  assign play_cnt_o = play_cnt_q;
  assign rel_cnt_o  = rel_cnt_q;

  `SVA_CHECK(a_lists_no_cmd_busy, busy_q |-> (cmd_i.op == sva_pkg::LOP_NONE), "List command while scanning.")
  `SVA_CHECK(a_lists_total, ({1'b0, play_cnt_q} + {1'b0, rel_cnt_q}) <= {1'b0, Full}, "Lists hold more voices than the pool.")
  `SVA_CHECK(a_lists_wr_behind, busy_q |-> (wr_idx_q <= rd_idx_q), "Compaction write overtook the read.")

endmodule
